// ----- rtl/utf8s_pkg.sv -----
// Package for the UTF-8 sanitizer: byte constants, lead decode and continuation check.
package utf8s_pkg;

  // Replacement character U+FFFD as UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;

  // Continuation byte limits
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] E0_MIN     = 8'hA0;
  localparam logic [7:0] ED_MAX     = 8'h9F;
  localparam logic [7:0] F0_MIN     = 8'h90;
  localparam logic [7:0] F4_MAX     = 8'h8F;

  // Output bytes one input word can cause: replacement plus a 4-byte character
  localparam int unsigned MAX_OUT = 7;
  localparam int unsigned OCNT_W  = $clog2(MAX_OUT + 1);
  localparam int unsigned HOLD_D  = 3;

  typedef logic [7:0]        byte_t;
  typedef logic [OCNT_W-1:0] ocnt_t;
  typedef logic [2:0]        seqlen_t;
  typedef logic [1:0]        hcnt_t;

  // Sequence length announced by a lead byte, 0 for a byte that cannot start one
  function automatic seqlen_t lead_length(byte_t b);
    seqlen_t len;
    case (b) inside
      [8'h00:8'h7F]:         len = 3'd1;
      [LEAD2_LO:LEAD2_HI]:   len = 3'd2;
      [LEAD3_LO:LEAD3_HI]:   len = 3'd3;
      [LEAD4_LO:LEAD4_HI]:   len = 3'd4;
      default:               len = 3'd0;
    endcase
    return len;
  endfunction

  // Is b a valid continuation at position pos after the given lead byte
  function automatic logic cont_ok(byte_t lead, hcnt_t pos, byte_t b);
    logic ok;
    ok = (b >= CONT_LO) && (b <= CONT_HI);
    if (pos == 2'd1) begin
      if (lead == LEAD3_LO && b < E0_MIN) ok = 1'b0;
      if (lead == LEAD_SURR && b > ED_MAX) ok = 1'b0;
      if (lead == LEAD4_LO && b < F0_MIN) ok = 1'b0;
      if (lead == LEAD4_HI && b > F4_MAX) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ----- rtl/utf8_sanitizer.sv -----
// UTF-8 sanitizer top level: validation, replacement and output byte buffer.
// The first output byte of an input word is shown in the cycle after the word is accepted.
// One input word is taken per cycle while each word yields at most one byte and out_stall is
// low; a word yielding n bytes (up to 7) holds the output buffer until they drain, one a cycle.
// The next word is taken in the same cycle the buffer's last byte leaves.
// Reset (rst_n low, synchronous) empties the buffer and clears the sequence state.
module utf8_sanitizer
  import utf8s_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_byte,
  input  logic  in_end_of_text,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_byte,
  output logic  out_run_last,
  output logic  out_text_done
);

  // Sequence state
  byte_t   held_r [HOLD_D];
  hcnt_t   held_cnt_r, held_cnt_nxt;
  seqlen_t exp_len_r, exp_len_nxt;
  logic    pend_r, pend_nxt;

  // Output buffer: entry 0 is the byte on the port
  byte_t   obuf_r [MAX_OUT];
  ocnt_t   ocnt_r;
  logic    oeot_r;

  // Next-word results
  byte_t   lst [MAX_OUT];
  ocnt_t   lst_n;
  logic    hold_wr;
  hcnt_t   hold_idx;

  logic in_fire, out_fire;

  assign out_valid = (ocnt_r != '0);
  assign out_fire  = out_valid && !out_stall;
  // accept when the buffer is empty or its last byte leaves now
  assign in_stall  = !((ocnt_r == '0) || ((ocnt_r == ocnt_t'(1)) && !out_stall));
  assign in_fire   = in_valid && !in_stall;

  assign out_byte      = obuf_r[0];
  assign out_run_last  = (ocnt_r == ocnt_t'(1));
  assign out_text_done = (ocnt_r == ocnt_t'(1)) && oeot_r;

  // Decode one word against the held sequence
  always_comb begin
    logic    start;
    seqlen_t len;
    held_cnt_nxt = held_cnt_r;
    exp_len_nxt  = exp_len_r;
    pend_nxt     = pend_r;
    hold_wr      = 1'b0;
    hold_idx     = held_cnt_r;
    start        = 1'b0;
    lst_n        = '0;
    for (int i = 0; i < MAX_OUT; i++) lst[i] = '0;

    if (exp_len_r != '0 && held_cnt_r != '0) begin
      if (cont_ok(held_r[0], held_cnt_r, in_byte)) begin
        if ({1'b0, held_cnt_r} + 3'd1 >= exp_len_r) begin
          // sequence complete: flush replacement, then the whole character
          if (pend_nxt) begin
            lst[lst_n] = REPL_B0; lst_n = lst_n + ocnt_t'(1);
            lst[lst_n] = REPL_B1; lst_n = lst_n + ocnt_t'(1);
            lst[lst_n] = REPL_B2; lst_n = lst_n + ocnt_t'(1);
            pend_nxt = 1'b0;
          end
          for (int k = 0; k < HOLD_D; k++) begin
            if (hcnt_t'(k) < held_cnt_r) begin
              lst[lst_n] = held_r[k];
              lst_n = lst_n + ocnt_t'(1);
            end
          end
          lst[lst_n] = in_byte; lst_n = lst_n + ocnt_t'(1);
          held_cnt_nxt = '0;
          exp_len_nxt  = '0;
        end else if (held_cnt_r != hcnt_t'(HOLD_D)) begin
          hold_wr      = 1'b1;
          held_cnt_nxt = held_cnt_r + hcnt_t'(1);
        end else begin
          pend_nxt     = 1'b1;
          held_cnt_nxt = '0;
          exp_len_nxt  = '0;
        end
      end else begin
        // broken sequence: held bytes go bad, byte is looked at again
        pend_nxt     = 1'b1;
        held_cnt_nxt = '0;
        exp_len_nxt  = '0;
        start        = 1'b1;
      end
    end else begin
      held_cnt_nxt = '0;
      exp_len_nxt  = '0;
      start        = 1'b1;
    end

    // new start byte
    len = lead_length(in_byte);
    if (start) begin
      if (len == 3'd0) begin
        pend_nxt = 1'b1;
      end else if (len == 3'd1) begin
        if (pend_nxt) begin
          lst[lst_n] = REPL_B0; lst_n = lst_n + ocnt_t'(1);
          lst[lst_n] = REPL_B1; lst_n = lst_n + ocnt_t'(1);
          lst[lst_n] = REPL_B2; lst_n = lst_n + ocnt_t'(1);
          pend_nxt = 1'b0;
        end
        lst[lst_n] = in_byte; lst_n = lst_n + ocnt_t'(1);
      end else begin
        hold_wr      = 1'b1;
        hold_idx     = '0;
        held_cnt_nxt = hcnt_t'(1);
        exp_len_nxt  = len;
      end
    end

    // end of text: unfinished sequence turns bad, pending replacement goes out
    if (in_end_of_text) begin
      if (held_cnt_nxt != '0) pend_nxt = 1'b1;
      held_cnt_nxt = '0;
      exp_len_nxt  = '0;
      if (pend_nxt) begin
        lst[lst_n] = REPL_B0; lst_n = lst_n + ocnt_t'(1);
        lst[lst_n] = REPL_B1; lst_n = lst_n + ocnt_t'(1);
        lst[lst_n] = REPL_B2; lst_n = lst_n + ocnt_t'(1);
        pend_nxt = 1'b0;
      end
    end
  end

  // Sequence state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      exp_len_r  <= '0;
      pend_r     <= 1'b0;
    end else if (in_fire) begin
      held_cnt_r <= held_cnt_nxt;
      exp_len_r  <= exp_len_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Held bytes, no reset
  always_ff @(posedge clk) begin
    if (in_fire && hold_wr) held_r[hold_idx] <= in_byte;
  end

  // Output buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
    end else if (in_fire) begin
      ocnt_r <= lst_n;
    end else if (out_fire) begin
      ocnt_r <= ocnt_r - ocnt_t'(1);
    end
  end

  // Output buffer bytes: load a word's results, shift down as bytes leave
  always_ff @(posedge clk) begin
    if (in_fire) begin
      obuf_r <= lst;
      oeot_r <= in_end_of_text;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_OUT - 1; i++) obuf_r[i] <= obuf_r[i + 1];
    end
  end

  // Held count and expected length are zero together
  a_held_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r == '0) == (exp_len_r == '0))
    else $error("held count and expected length disagree");

  // A held sequence is always shorter than announced and its lead matches
  a_held_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r != '0) |-> (({1'b0, held_cnt_r} < exp_len_r) &&
                            (lead_length(held_r[0]) == exp_len_r)))
    else $error("held sequence inconsistent with its lead byte");

  // End of text leaves clean state and at least one output byte
  a_eot_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_text) |=> (held_cnt_r == '0 && !pend_r && ocnt_r != '0))
    else $error("end of text did not flush");

  // Buffer never holds more than the most bytes one word can cause
  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (ocnt_r <= ocnt_t'(MAX_OUT)))
    else $error("output count out of range");

endmodule

// ----- tb/tb_utf8_sanitizer.sv -----
// Testbench for utf8_sanitizer: directed and random byte texts checked against a predictor.
module tb_utf8_sanitizer
  import utf8s_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 90;
  localparam int END_PAUSE   = 20;

  typedef struct {
    byte_t b;
    logic  eot;
  } raw_word_t;

  typedef struct {
    byte_t b;
    logic  run_last;
    logic  text_done;
  } clean_word_t;

  logic  clk;
  logic  rst_n          = 1'b0;
  logic  in_valid       = 1'b0;
  logic  in_stall;
  byte_t in_byte        = '0;
  logic  in_end_of_text = 1'b0;
  logic  out_valid;
  logic  out_stall      = 1'b0;
  byte_t out_byte;
  logic  out_run_last;
  logic  out_text_done;

  utf8_sanitizer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_end_of_text(in_end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done)
  );

  // Raw text waiting to be sent, sanitized bytes waiting to come out
  raw_word_t   raw_q[$];
  clean_word_t clean_q[$];
  int          queued_total   = 0;
  int          err_count      = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  bit          hold_req       = 1'b0;
  bit          hold_done      = 1'b0;
  int          quiet          = 0;

  // Predictor state: the partial sequence and the pending U+FFFD
  byte_t       held[3];
  int          held_cnt = 0;
  int          seq_len  = 0;
  bit          repl_due = 1'b0;
  clean_word_t step_out[7];
  int          step_n;

  // Scratch for building one character of stimulus
  byte_t chr[$];

  // Three texts: bad leads, broken second bytes, trailing unfinished sequences
  byte_t directed_text [0:25] = '{
    8'h00, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hC1, 8'hF5, 8'hFF, 8'h7F,
    8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90, 8'hE2, 8'h82,
    8'hDF, 8'hBF, 8'hE2, 8'h82
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    if (err_count < 100) $display("[%0t] mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int char_len(byte_t b);
    if (b <= 8'h7F) return 1;
    if (b >= LEAD2_LO && b <= LEAD2_HI) return 2;
    if (b >= LEAD3_LO && b <= LEAD3_HI) return 3;
    if (b >= LEAD4_LO && b <= LEAD4_HI) return 4;
    return 0;
  endfunction

  // Second byte has tighter limits after E0, ED, F0 and F4
  function automatic bit cont_fits(byte_t lead, int pos, byte_t b);
    byte_t lo;
    byte_t hi;
    lo = CONT_LO;
    hi = CONT_HI;
    if (pos == 1) begin
      case (lead)
        LEAD3_LO:  lo = E0_MIN;
        LEAD_SURR: hi = ED_MAX;
        LEAD4_LO:  lo = F0_MIN;
        LEAD4_HI:  hi = F4_MAX;
        default: ;
      endcase
    end
    return (b >= lo) && (b <= hi);
  endfunction

  task automatic emit(input byte_t b);
    step_out[step_n].b         = b;
    step_out[step_n].run_last  = 1'b0;
    step_out[step_n].text_done = 1'b0;
    step_n++;
  endtask

  task automatic flush_repl();
    if (repl_due) begin
      emit(REPL_B0);
      emit(REPL_B1);
      emit(REPL_B2);
      repl_due = 1'b0;
    end
  endtask

  task automatic start_char(input byte_t b);
    int len;
    len = char_len(b);
    if (len == 0) begin
      repl_due = 1'b1;
    end else if (len == 1) begin
      flush_repl();
      emit(b);
    end else begin
      held[0]  = b;
      held_cnt = 1;
      seq_len  = len;
    end
  endtask

  // Works out the sanitized bytes caused by one accepted input word
  task automatic sanitize_byte(input byte_t b, input logic eot);
    int k;
    step_n = 0;
    if (seq_len != 0) begin
      if (cont_fits(held[0], held_cnt, b)) begin
        if (held_cnt + 1 >= seq_len) begin
          flush_repl();
          for (k = 0; k < held_cnt; k++) emit(held[k]);
          emit(b);
          held_cnt = 0;
          seq_len  = 0;
        end else begin
          held[held_cnt] = b;
          held_cnt++;
        end
      end else begin
        // held bytes join the bad run, the breaking byte starts over
        repl_due = 1'b1;
        held_cnt = 0;
        seq_len  = 0;
        start_char(b);
      end
    end else begin
      start_char(b);
    end
    if (eot) begin
      if (held_cnt != 0) repl_due = 1'b1;
      held_cnt = 0;
      seq_len  = 0;
      flush_repl();
    end
    if (step_n > 0) begin
      step_out[step_n-1].run_last = 1'b1;
      if (eot) step_out[step_n-1].text_done = 1'b1;
    end
    for (k = 0; k < step_n; k++) clean_q.insert(clean_q.size(), step_out[k]);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_raw(input byte_t b, input logic eot);
    raw_word_t w;
    w.b   = b;
    w.eot = eot;
    raw_q.insert(raw_q.size(), w);
    queued_total++;
  endtask

  // Range ends come up half the time
  function automatic byte_t pick_in(int lo, int hi);
    int r;
    r = $urandom_range(3);
    if (r == 0) return byte_t'(lo);
    if (r == 1) return byte_t'(hi);
    return byte_t'($urandom_range(hi, lo));
  endfunction

  // One well-formed character of the given length into chr
  task automatic make_char(input int len);
    byte_t lead;
    byte_t lo2;
    byte_t hi2;
    int    k;
    chr.delete();
    case (len)
      1: lead = pick_in(8'h00, 8'h7F);
      2: lead = pick_in(LEAD2_LO, LEAD2_HI);
      3: begin
        if ($urandom_range(1) == 1) lead = ($urandom_range(1) == 1) ? LEAD3_LO : LEAD_SURR;
        else lead = byte_t'($urandom_range(LEAD3_HI, LEAD3_LO));
      end
      default: lead = pick_in(LEAD4_LO, LEAD4_HI);
    endcase
    chr.insert(chr.size(), lead);
    lo2 = CONT_LO;
    hi2 = CONT_HI;
    case (lead)
      LEAD3_LO:  lo2 = E0_MIN;
      LEAD_SURR: hi2 = ED_MAX;
      LEAD4_LO:  lo2 = F0_MIN;
      LEAD4_HI:  hi2 = F4_MAX;
      default: ;
    endcase
    for (k = 1; k < len; k++)
      chr.insert(chr.size(), (k == 1) ? pick_in(lo2, hi2) : pick_in(CONT_LO, CONT_HI));
  endtask

  // Truncated multi-byte character, often followed by a byte that breaks it
  task automatic make_broken();
    int    len;
    int    cut;
    byte_t lead;
    bit    limited;
    len = $urandom_range(4, 2);
    make_char(len);
    lead = chr[0];
    cut  = $urandom_range(len - 1, 1);
    while (chr.size() > cut) void'(chr.pop_back());
    limited = (lead == LEAD3_LO) || (lead == LEAD_SURR) || (lead == LEAD4_LO) ||
              (lead == LEAD4_HI);
    if ($urandom_range(99) < 60) begin
      if (cut == 1 && limited && $urandom_range(1) == 1) begin
        // continuation byte just outside the second-byte window
        case (lead)
          LEAD3_LO:  chr.insert(chr.size(), byte_t'($urandom_range(8'h9F, 8'h80)));
          LEAD_SURR: chr.insert(chr.size(), byte_t'($urandom_range(8'hBF, 8'hA0)));
          LEAD4_LO:  chr.insert(chr.size(), byte_t'($urandom_range(8'h8F, 8'h80)));
          default:   chr.insert(chr.size(), byte_t'($urandom_range(8'hBF, 8'h90)));
        endcase
      end else if ($urandom_range(1) == 1) begin
        chr.insert(chr.size(), byte_t'($urandom_range(8'h7F, 8'h00)));
      end else begin
        chr.insert(chr.size(), byte_t'($urandom_range(8'hFF, 8'hC0)));
      end
    end
  endtask

  // One text: mostly clean characters, some texts salted with noise
  task automatic queue_text();
    byte_t text[$];
    int    n_chars;
    int    kind;
    bit    noisy;
    int    i;
    noisy   = ($urandom_range(99) < 35);
    n_chars = $urandom_range(8, 1);
    for (i = 0; i < n_chars; i++) begin
      kind = noisy ? $urandom_range(99) : 0;
      if (kind < 60) begin
        make_char($urandom_range(4, 1));
      end else if (kind < 80) begin
        make_broken();
      end else begin
        chr.delete();
        chr.insert(chr.size(), byte_t'($urandom_range(255)));
      end
      foreach (chr[j]) text.insert(text.size(), chr[j]);
    end
    foreach (text[j]) push_raw(text[j], j == text.size() - 1);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n, input bit pressure);
    int start;
    @(negedge clk);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    hold_req       = pressure;
    start          = queued_total;
    while (queued_total - start < n) queue_text();
    while (!(raw_q.size() == 0 && !in_valid && clean_q.size() == 0)) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : driver
    raw_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      held_cnt = 0;
      seq_len  = 0;
      repl_due = 1'b0;
    end else begin
      if (in_valid && !in_stall) sanitize_byte(in_byte, in_end_of_text);
      // a stalled word stays put; otherwise offer the next one or idle
      if (!in_valid || !in_stall) begin
        if (raw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = raw_q.pop_front();
          in_valid       <= 1'b1;
          in_byte        <= w.b;
          in_end_of_text <= w.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, fired once when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    clean_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (clean_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", out_byte));
      end else begin
        want = clean_q.pop_front();
        if (out_byte !== want.b)
          report($sformatf("out_byte %02h, want %02h", out_byte, want.b));
        if (out_run_last !== want.run_last)
          report($sformatf("out_run_last %b, want %b (byte %02h)", out_run_last, want.run_last,
                           want.b));
        if (out_text_done !== want.text_done)
          report($sformatf("out_text_done %b, want %b (byte %02h)", out_text_done,
                           want.text_done, want.b));
      end
    end
  end

  // Watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("utf8_sanitizer verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : sequencer
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // text ends fall on the 7F, on the first trailing 82 and on the last byte
    for (i = 0; i < 26; i++) push_raw(directed_text[i], i == 11 || i == 21 || i == 25);
    run_phase(0, 0, 55, 1'b0);
    run_phase(0, 0, 40, 1'b1);
    run_phase(63, 0, 65, 1'b0);
    run_phase(0, 63, 65, 1'b0);
    run_phase(18, 18, 65, 1'b0);
    repeat (END_PAUSE) @(posedge clk);
    if (err_count == 0) begin
      $display("utf8_sanitizer verification clean");
    end else begin
      $display("utf8_sanitizer verification failed");
    end
    $finish;
  end

endmodule
